// ===== hw/rtl/json_string_field_extractor_defines.svh =====
// Assertion macros for the JSON string field extractor.
// No dependencies; the top level takes this file in with an include.
`ifndef JSON_STRING_FIELD_EXTRACTOR_DEFINES_SVH
`define JSON_STRING_FIELD_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
// The expression must hold at every clock edge outside reset.
`define JSFE_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");
// The consequent must hold in the cycle after the antecedent.
`define JSFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence violated");
`else
`define JSFE_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define JSFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/jsfe_pkg.sv =====
// Shared types, constants and helper functions of the JSON string field extractor.
// No dependencies; used by jsfe_decode, jsfe_out and the top level.
package jsfe_pkg;

    localparam int unsigned KEY_MAX_BYTES = 16;
    localparam int unsigned CAPACITY_MAX  = 65536;
    localparam int unsigned MAX_RESULTS   = 4;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN  = 2'd2;
    localparam logic [1:0] CFG_CAPACITY = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_COLON  = 3'd1,
        PH_QUOTE  = 3'd2,
        PH_STRING = 3'd3,
        PH_ESCAPE = 3'd4,
        PH_HEX    = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  match_count;
        logic [2:0]  hex_seen;
        logic [15:0] code_point;
        logic [16:0] bytes_written;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_SEARCH, match_count: 5'd0, hex_seen: 3'd0,
        code_point: 16'd0, bytes_written: 17'd0
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [2:0]                count;
    } t_bundle;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    // Returns a valid flag in bit 4 and the digit value in bits 3:0.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// ===== hw/rtl/json_string_field_extractor.sv =====
// JSON string field extractor, top level: configuration registers, input
// register, parser state and the result stage. Depends on jsfe_pkg,
// jsfe_decode, jsfe_out and json_string_field_extractor_defines.svh.
//
// Usage. Body bytes arrive on the input channel (i_valid, o_stall, i_in_byte,
// i_end_of_body); an item is taken at an edge with i_valid high and o_stall
// low. Results leave on the output channel (o_valid, i_stall, o_out_kind,
// o_out_byte, o_run_last), one result per cycle while i_stall is low, in
// order. A byte yields from zero to four results; o_run_last marks the last
// result of a byte. An accepted byte is registered, decoded once the result
// stage is free and its results registered there before the first is shown.
// Throughput is one byte per cycle while each byte yields at most one result
// and i_stall is low; a byte with more results holds the result stage until
// they have all left, and input stalls meanwhile.
// Reset (synchronous, active low) clears the parser to key search, empties
// both stages and loads the register defaults (empty key, capacity 65536).
// When the receiver stalls, the result on the ports holds; one further byte
// waits in the input register and then o_stall rises until results drain.
// Configuration writes take effect on the next edge and are meant for idle.
`include "json_string_field_extractor_defines.svh"

module json_string_field_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_body,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last
);

    // Configuration registers.
    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic [4:0]  r_key_len;
    logic [16:0] r_capacity;

    // Effective values: the key length is clamped to the key store and a
    // capacity of zero behaves as one (nothing may be emitted).
    logic [4:0]  key_len_eff;
    logic [16:0] cap_eff;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eob;

    // Parser state, updated when the registered byte moves on.
    jsfe_pkg::t_state  r_st;
    jsfe_pkg::t_state  n_st;
    jsfe_pkg::t_bundle bundle;

    logic res_free;
    logic move;
    logic accept;

    assign key_len_eff = (r_key_len > 5'(jsfe_pkg::KEY_MAX_BYTES))
                         ? 5'(jsfe_pkg::KEY_MAX_BYTES) : r_key_len;
    assign cap_eff = (r_capacity == 17'd0) ? 17'd1
                   : (r_capacity > 17'(jsfe_pkg::CAPACITY_MAX))
                     ? 17'(jsfe_pkg::CAPACITY_MAX) : r_capacity;

    // The byte in the input register is decoded as soon as the result stage
    // can take its results; a byte with no results still advances the state.
    assign move    = r_in_valid && res_free;
    assign o_stall = r_in_valid && !res_free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= 64'd0;
            r_key_high <= 64'd0;
            r_key_len  <= 5'd0;
            r_capacity <= 17'(jsfe_pkg::CAPACITY_MAX);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jsfe_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                jsfe_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                jsfe_pkg::CFG_KEY_LEN:  r_key_len  <= i_cfg_data[4:0];
                jsfe_pkg::CFG_CAPACITY: r_capacity <= i_cfg_data[16:0];
                default:                r_key_len  <= r_key_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_eob  <= i_end_of_body;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= jsfe_pkg::STATE_RESET;
        end else if (move) begin
            r_st <= n_st;
        end
    end

    jsfe_decode u_decode (
        .i_state    (r_st),
        .i_byte     (r_in_byte),
        .i_eob      (r_in_eob),
        .i_key      ({r_key_high, r_key_low}),
        .i_key_len  (key_len_eff),
        .i_capacity (cap_eff),
        .o_state    (n_st),
        .o_bundle   (bundle)
    );

    jsfe_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (move && (bundle.count != 3'd0)),
        .i_bundle (bundle),
        .i_stall  (i_stall),
        .o_free   (res_free),
        .o_valid  (o_valid),
        .o_kind   (o_out_kind),
        .o_byte   (o_out_byte),
        .o_last   (o_run_last)
    );

    // At most three hex digits are ever held between escape steps.
    `JSFE_ASSERT_ALWAYS(a_hex_bound, i_clk, i_rst_n, r_st.hex_seen <= 3'd3)
    // Digit count and partial code point are clear outside a \u escape,
    // except after a verdict that broke one off part way.
    `JSFE_ASSERT_ALWAYS(a_hex_idle, i_clk, i_rst_n, (r_st.phase == jsfe_pkg::PH_HEX) || (r_st.phase == jsfe_pkg::PH_DONE) || (r_st.hex_seen == 3'd0 && r_st.code_point == 16'd0))
    // A byte blocked by a busy result stage stays in the input register.
    `JSFE_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !res_free, r_in_valid)

endmodule

// ===== hw/rtl/jsfe_decode.sv =====
// Next-state and result logic for one body byte of the field extractor.
// Depends on jsfe_pkg.
module jsfe_decode (
    input  jsfe_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_eob,
    input  logic [127:0]      i_key,
    input  logic [4:0]        i_key_len,
    input  logic [16:0]       i_capacity,
    output jsfe_pkg::t_state  o_state,
    output jsfe_pkg::t_bundle o_bundle
);

    logic [7:0]  needle;
    logic [3:0]  key_idx;
    logic [4:0]  mc_dec;
    logic [4:0]  hv;
    logic [15:0] cp;
    logic [17:0] bw_ext;
    logic [17:0] cap_ext;
    logic        room1;
    logic        room2;
    logic        room3;
    logic [7:0]  esc;
    logic        esc_ok;

    assign mc_dec  = i_state.match_count - 5'd1;
    assign key_idx = mc_dec[3:0];
    assign needle  = (i_state.match_count == 5'd0 || i_state.match_count > i_key_len)
                     ? jsfe_pkg::CH_QUOTE : i_key[key_idx*8 +: 8];
    assign hv      = jsfe_pkg::hex_value(i_byte);
    assign cp      = {i_state.code_point[11:0], hv[3:0]};
    assign bw_ext  = {1'b0, i_state.bytes_written};
    assign cap_ext = {1'b0, i_capacity};
    assign room1   = (bw_ext + 18'd1) < cap_ext;
    assign room2   = (bw_ext + 18'd2) < cap_ext;
    assign room3   = (bw_ext + 18'd3) < cap_ext;

    always_comb begin
        esc_ok = 1'b1;
        unique case (i_byte)
            8'h22:   esc = 8'h22;
            8'h5C:   esc = 8'h5C;
            8'h2F:   esc = 8'h2F;
            8'h6E:   esc = 8'h0A;
            8'h72:   esc = 8'h0D;
            8'h74:   esc = 8'h09;
            8'h62:   esc = 8'h08;
            8'h66:   esc = 8'h0C;
            default: begin
                esc    = 8'h00;
                esc_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        jsfe_pkg::t_state n_st;
        jsfe_pkg::t_bundle bnd;
        logic [1:0] verdict;
        logic       has_verdict;
        n_st        = i_state;
        bnd         = '0;
        verdict     = jsfe_pkg::KIND_FAIL;
        has_verdict = 1'b0;

        if (i_state.phase == jsfe_pkg::PH_DONE) begin
            has_verdict = 1'b0;
        end else if (i_byte == 8'h00) begin
            has_verdict = 1'b1;
        end else begin
            unique case (i_state.phase)
                jsfe_pkg::PH_SEARCH: begin
                    if (i_byte == needle) begin
                        n_st.match_count = i_state.match_count + 5'd1;
                        if ({1'b0, n_st.match_count} >= {1'b0, i_key_len} + 6'd2) begin
                            n_st.phase = jsfe_pkg::PH_COLON;
                        end
                    end else begin
                        n_st.match_count = (i_byte == jsfe_pkg::CH_QUOTE) ? 5'd1 : 5'd0;
                    end
                end
                jsfe_pkg::PH_COLON: begin
                    if (i_byte == jsfe_pkg::CH_COLON) begin
                        n_st.phase = jsfe_pkg::PH_QUOTE;
                    end else if (!jsfe_pkg::is_ws(i_byte)) begin
                        has_verdict = 1'b1;
                    end
                end
                jsfe_pkg::PH_QUOTE: begin
                    if (i_byte == jsfe_pkg::CH_QUOTE) begin
                        n_st.phase = jsfe_pkg::PH_STRING;
                    end else if (!jsfe_pkg::is_ws(i_byte)) begin
                        has_verdict = 1'b1;
                    end
                end
                jsfe_pkg::PH_STRING: begin
                    if (i_byte == jsfe_pkg::CH_QUOTE) begin
                        has_verdict = 1'b1;
                        verdict     = jsfe_pkg::KIND_OK;
                    end else if (i_byte == jsfe_pkg::CH_BSLASH) begin
                        n_st.phase = jsfe_pkg::PH_ESCAPE;
                    end else if (room1) begin
                        bnd.res[0]         = '{kind: jsfe_pkg::KIND_DATA, data: i_byte};
                        bnd.count          = 3'd1;
                        n_st.bytes_written = i_state.bytes_written + 17'd1;
                    end
                end
                jsfe_pkg::PH_ESCAPE: begin
                    if (i_byte == 8'h75) begin
                        n_st.phase      = jsfe_pkg::PH_HEX;
                        n_st.hex_seen   = 3'd0;
                        n_st.code_point = 16'd0;
                    end else if (esc_ok) begin
                        n_st.phase = jsfe_pkg::PH_STRING;
                        if (room1) begin
                            bnd.res[0]         = '{kind: jsfe_pkg::KIND_DATA, data: esc};
                            bnd.count          = 3'd1;
                            n_st.bytes_written = i_state.bytes_written + 17'd1;
                        end
                    end else begin
                        has_verdict = 1'b1;
                    end
                end
                jsfe_pkg::PH_HEX: begin
                    if (!hv[4]) begin
                        has_verdict = 1'b1;
                    end else if (i_state.hex_seen == 3'd3) begin
                        // Fourth digit: emit the whole UTF-8 group or nothing.
                        n_st.hex_seen   = 3'd0;
                        n_st.code_point = 16'd0;
                        n_st.phase      = jsfe_pkg::PH_STRING;
                        if (cp < 16'h0080) begin
                            if (room1) begin
                                bnd.res[0] = '{kind: jsfe_pkg::KIND_DATA, data: cp[7:0]};
                                bnd.count  = 3'd1;
                                n_st.bytes_written = i_state.bytes_written + 17'd1;
                            end
                        end else if (cp < 16'h0800) begin
                            if (room2) begin
                                bnd.res[0] = '{kind: jsfe_pkg::KIND_DATA,
                                               data: {3'b110, cp[10:6]}};
                                bnd.res[1] = '{kind: jsfe_pkg::KIND_DATA,
                                               data: {2'b10, cp[5:0]}};
                                bnd.count  = 3'd2;
                                n_st.bytes_written = i_state.bytes_written + 17'd2;
                            end
                        end else if (room3) begin
                            bnd.res[0] = '{kind: jsfe_pkg::KIND_DATA,
                                           data: {4'b1110, cp[15:12]}};
                            bnd.res[1] = '{kind: jsfe_pkg::KIND_DATA,
                                           data: {2'b10, cp[11:6]}};
                            bnd.res[2] = '{kind: jsfe_pkg::KIND_DATA,
                                           data: {2'b10, cp[5:0]}};
                            bnd.count  = 3'd3;
                            n_st.bytes_written = i_state.bytes_written + 17'd3;
                        end
                    end else begin
                        n_st.code_point = cp;
                        n_st.hex_seen   = i_state.hex_seen + 3'd1;
                    end
                end
                default: begin
                    has_verdict = 1'b1;
                end
            endcase
        end

        if (has_verdict) begin
            bnd.res[bnd.count[1:0]] = '{kind: verdict, data: 8'h00};
            bnd.count               = bnd.count + 3'd1;
            n_st.phase              = jsfe_pkg::PH_DONE;
        end
        if (i_eob) begin
            if (n_st.phase != jsfe_pkg::PH_DONE) begin
                bnd.res[bnd.count[1:0]] = '{kind: jsfe_pkg::KIND_FAIL, data: 8'h00};
                bnd.count               = bnd.count + 3'd1;
            end
            n_st = jsfe_pkg::STATE_RESET;
        end

        o_state  = n_st;
        o_bundle = bnd;
    end

endmodule

// ===== hw/rtl/jsfe_out.sv =====
// Result register of the field extractor: holds the results of one byte and
// hands them out one per cycle while i_stall is low. Depends on jsfe_pkg.
module jsfe_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jsfe_pkg::t_bundle i_bundle,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_byte,
    output logic              o_last
);

    logic              r_valid;
    logic [1:0]        r_idx;
    jsfe_pkg::t_bundle r_bundle;
    logic              pop;
    logic              done;

    assign o_valid = r_valid;
    assign o_last  = ({1'b0, r_idx} + 3'd1) == r_bundle.count;
    assign o_kind  = r_bundle.res[r_idx].kind;
    assign o_byte  = r_bundle.res[r_idx].data;
    assign pop     = r_valid && !i_stall;
    assign done    = pop && o_last;
    assign o_free  = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule
